[sv/tfd_pkg.sv]
// shared types and constants of the telemetry frame deframer
package tfd_pkg;

  localparam int unsigned FRAME_BYTES = 36;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam int unsigned FIELD_COUNT = 18;
  localparam int unsigned WORD_FIELDS = 11;

  localparam logic [7:0] FLAG_FIRST  = 8'hAA;
  localparam logic [7:0] FLAG_SECOND = 8'h55;
  localparam logic [7:0] END_MARK    = 8'hCC;

  typedef enum logic [1:0] {
    RK_FIELD   = 2'd0,
    RK_SUM_ERR = 2'd1,
    RK_END_ERR = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [4:0]  field_index;
    logic [15:0] field_value;
    logic        last;
  } out_item_t;

endpackage

[sv/tfd_stream_if.sv]
// valid/ready channel carrying one payload item per transfer
interface tfd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/telemetry_frame_deframer.sv]
// Telemetry frame deframer: hunts for the 0xAA 0x55 header, collects a
// 36-byte frame into a single-port-read frame store, checks the 8-bit sum of
// bytes 0..33 against byte 34 and the end byte 0xCC, then emits 18 fields.
// While hunting or collecting, one byte is taken per cycle, but the last byte
// of a frame is held off while an older result is pending. A rejected frame
// gives one error result from the output register with no pause. After a good
// frame no byte is taken while the fields are read out of the frame store, one
// byte per read: two for each of the eleven 16-bit fields, one for each of the
// seven byte fields. The frame store needs no clearing after reset.
module telemetry_frame_deframer (
  input  logic         clk,
  input  logic         rst,
  tfd_stream_if.sink   rx,
  tfd_stream_if.source tx
);

  localparam int unsigned PW = tfd_pkg::POS_W;

  typedef enum logic [1:0] {
    H_FIRST   = 2'd0,
    H_SECOND  = 2'd1,
    H_COLLECT = 2'd2
  } hunt_t;

  typedef enum logic [1:0] {
    S_RUN   = 2'd0,
    S_RD_HI = 2'd1,
    S_RD_LO = 2'd2,
    S_LOAD  = 2'd3
  } state_t;

  state_t          state;
  hunt_t           hunt;
  logic [PW-1:0]   pos;
  logic [7:0]      sum;
  logic [7:0]      chk_byte;
  logic [4:0]      fidx;
  logic [7:0]      hi_byte;

  logic            out_valid;
  tfd_pkg::out_item_t out_item;

  // frame store
  logic [7:0]      mem [tfd_pkg::FRAME_BYTES];
  logic            wr_en;
  logic            rd_en;
  logic [PW-1:0]   rd_addr;
  logic [7:0]      rd_data;

  logic [7:0]      b;
  logic            in_xfer;
  logic            out_free;
  logic            frame_end;
  logic            is_word;
  logic [PW-1:0]   hi_addr;
  logic [PW-1:0]   lo_addr;
  logic [PW-1:0]   byte_addr;

  assign b         = rx.data.rx_byte;
  assign out_free  = !out_valid || tx.ready;
  assign frame_end = (hunt == H_COLLECT) && (pos == PW'(tfd_pkg::FRAME_BYTES - 1));
  // hold off the final byte of a frame while an older result still waits
  assign rx.ready  = (state == S_RUN) && !(frame_end && !out_free);
  assign in_xfer   = rx.valid && rx.ready;
  assign wr_en     = in_xfer && (hunt == H_COLLECT);

  assign is_word   = fidx < 5'(tfd_pkg::WORD_FIELDS);
  assign hi_addr   = PW'(5) + PW'({fidx, 1'b0});
  assign lo_addr   = hi_addr + PW'(1);
  assign byte_addr = PW'(16) + PW'(fidx);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = byte_addr;
    case (state)
      S_RD_HI: begin
        rd_en   = 1'b1;
        rd_addr = is_word ? hi_addr : byte_addr;
      end
      S_RD_LO: begin
        rd_en   = 1'b1;
        rd_addr = lo_addr;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = byte_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      hunt      <= H_FIRST;
      pos       <= '0;
      sum       <= '0;
      fidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && tx.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_RUN: begin
          if (in_xfer) begin
            case (hunt)
              H_SECOND: begin
                if (b == tfd_pkg::FLAG_SECOND) begin
                  hunt <= H_COLLECT;
                  pos  <= PW'(2);
                  sum  <= tfd_pkg::FLAG_FIRST + tfd_pkg::FLAG_SECOND;
                end else if (b != tfd_pkg::FLAG_FIRST) begin
                  hunt <= H_FIRST;
                end
              end
              H_COLLECT: begin
                if (pos < PW'(tfd_pkg::FRAME_BYTES - 2)) begin
                  sum <= sum + b;
                end
                if (pos == PW'(tfd_pkg::FRAME_BYTES - 2)) begin
                  chk_byte <= b;
                end
                pos <= pos + PW'(1);
                if (frame_end) begin
                  hunt <= H_FIRST;
                  pos  <= '0;
                  out_item.field_index <= '0;
                  out_item.field_value <= '0;
                  out_item.last        <= 1'b1;
                  if (sum != chk_byte) begin
                    out_valid            <= 1'b1;
                    out_item.result_kind <= tfd_pkg::RK_SUM_ERR;
                  end else if (b != tfd_pkg::END_MARK) begin
                    out_valid            <= 1'b1;
                    out_item.result_kind <= tfd_pkg::RK_END_ERR;
                  end else begin
                    state <= S_RD_HI;
                    fidx  <= '0;
                  end
                end
              end
              default: begin
                hunt <= (b == tfd_pkg::FLAG_FIRST) ? H_SECOND : H_FIRST;
              end
            endcase
          end
        end
        S_RD_HI: begin
          state <= is_word ? S_RD_LO : S_LOAD;
        end
        S_RD_LO: begin
          hi_byte <= rd_data;
          state   <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_item.result_kind <= tfd_pkg::RK_FIELD;
            out_item.field_index <= fidx;
            out_item.field_value <= is_word ? {hi_byte, rd_data} : {8'h00, rd_data};
            out_item.last        <= (fidx == 5'(tfd_pkg::FIELD_COUNT - 1));
            fidx                 <= fidx + 5'd1;
            state <= (fidx == 5'(tfd_pkg::FIELD_COUNT - 1)) ? S_RUN : S_RD_HI;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

  assign tx.valid = out_valid;
  assign tx.data  = out_item;

  // no byte is taken while fields are being read out
  a_no_input_in_readout: assert property (@(posedge clk) disable iff (rst)
    (state != S_RUN) |-> !rx.ready)
    else $error("byte accepted during field readout");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && (tx.data.result_kind != tfd_pkg::RK_FIELD)) |-> tx.data.last)
    else $error("error result not marked last");

  a_last_field_index: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && (tx.data.result_kind == tfd_pkg::RK_FIELD) && tx.data.last)
      |-> (tx.data.field_index == 5'(tfd_pkg::FIELD_COUNT - 1)))
    else $error("last marked on wrong field");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    pos < PW'(tfd_pkg::FRAME_BYTES))
    else $error("byte position beyond frame");

  a_readout_starts_clean: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_RUN && state == S_RD_HI) |-> (fidx == 5'd0 && hunt == H_FIRST))
    else $error("readout started in wrong state");

endmodule

[tb/telemetry_frame_deframer_tb.sv]
// testbench for the telemetry frame deframer: byte stream in, predicted fields checked
module telemetry_frame_deframer_tb;
  import tfd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 70;
  localparam int DRAIN_CYCLES = 100;

  // frame flaws
  localparam int FLAW_NONE = 0;
  localparam int FLAW_SUM  = 1;
  localparam int FLAW_END  = 2;
  localparam int FLAW_BOTH = 3;

  // frame contents
  localparam int PAT_RANDOM = 0;
  localparam int PAT_ZEROS  = 1;
  localparam int PAT_ONES   = 2;
  localparam int PAT_SIGN   = 3;
  localparam int PAT_FLAGS  = 4;

  typedef enum logic [1:0] {
    HUNT_FIRST  = 2'd0,
    HUNT_SECOND = 2'd1,
    COLLECT     = 2'd2
  } hunt_t;

  logic clk = 1'b0;
  logic rst;

  tfd_stream_if #(.T(in_item_t))  rx_if ();
  tfd_stream_if #(.T(out_item_t)) tx_if ();

  telemetry_frame_deframer u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  always #2 clk = ~clk;

  logic [7:0] byte_q [$];
  out_item_t  expected_fields [$];
  int         stim_total = 1;
  int         bytes_sent = 0;
  int         err_cnt    = 0;
  int         cycle_cnt  = 0;

  // predictor state
  hunt_t      hunt      = HUNT_FIRST;
  int         frame_pos = 0;
  logic [7:0] frame_sum = 8'h00;
  logic [7:0] frame_buf [FRAME_BYTES];

  function automatic int idle_mode();
    int m;
    m = (bytes_sent * 3) / stim_total;
    return (m > 2) ? 2 : m;
  endfunction

  function automatic int sender_idle_pct(int mode);
    case (mode)
      0: return 15;
      1: return 67;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(int mode);
    case (mode)
      0: return 67;
      1: return 15;
      default: return 0;
    endcase
  endfunction

  task automatic push_result(input result_kind_t kind, input logic [4:0] idx,
                             input logic [15:0] val, input logic last);
    out_item_t r;
    r.result_kind = kind;
    r.field_index = idx;
    r.field_value = val;
    r.last        = last;
    expected_fields.push_back(r);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0] val;
    case (hunt)
      HUNT_SECOND: begin
        if (b == FLAG_SECOND) begin
          frame_buf[0] = FLAG_FIRST;
          frame_buf[1] = FLAG_SECOND;
          frame_pos    = 2;
          frame_sum    = FLAG_FIRST + FLAG_SECOND;
          hunt         = COLLECT;
        end else if (b != FLAG_FIRST) begin
          hunt = HUNT_FIRST;
        end
      end
      COLLECT: begin
        frame_buf[frame_pos] = b;
        if (frame_pos < FRAME_BYTES - 2) frame_sum = frame_sum + b;
        frame_pos++;
        if (frame_pos == FRAME_BYTES) begin
          hunt      = HUNT_FIRST;
          frame_pos = 0;
          // checksum is judged before the end byte
          if (frame_sum != frame_buf[FRAME_BYTES-2]) begin
            push_result(RK_SUM_ERR, 5'd0, 16'h0000, 1'b1);
          end else if (frame_buf[FRAME_BYTES-1] != END_MARK) begin
            push_result(RK_END_ERR, 5'd0, 16'h0000, 1'b1);
          end else begin
            for (int i = 0; i < FIELD_COUNT; i++) begin
              if (i < WORD_FIELDS) val = {frame_buf[5+2*i], frame_buf[6+2*i]};
              else val = {8'h00, frame_buf[16+i]};
              push_result(RK_FIELD, 5'(i), val, i == FIELD_COUNT - 1);
            end
          end
        end
      end
      default: hunt = (b == FLAG_FIRST) ? HUNT_SECOND : HUNT_FIRST;
    endcase
  endtask

  task automatic add_frame(input int flaw, input int pattern);
    logic [7:0] f [FRAME_BYTES];
    logic [7:0] s;
    logic [7:0] e;
    f[0] = FLAG_FIRST;
    f[1] = FLAG_SECOND;
    for (int p = 2; p < FRAME_BYTES - 2; p++) begin
      case (pattern)
        PAT_ZEROS: f[p] = 8'h00;
        PAT_ONES:  f[p] = 8'hFF;
        // words alternate most negative and most positive
        PAT_SIGN:  f[p] = (p < 27) ? ((((p - 5) / 2) % 2 == 0) ? ((p % 2) ? 8'h80 : 8'h00)
                                                              : ((p % 2) ? 8'h7F : 8'hFF))
                                   : ((p % 2) ? 8'h80 : 8'h7F);
        PAT_FLAGS: f[p] = (p % 2 == 0) ? FLAG_FIRST : FLAG_SECOND;
        default:   f[p] = 8'($urandom_range(255));
      endcase
    end
    s = 8'h00;
    for (int p = 0; p < FRAME_BYTES - 2; p++) s = s + f[p];
    if (flaw == FLAW_SUM || flaw == FLAW_BOTH) s = s + 8'($urandom_range(1, 255));
    e = END_MARK;
    if (flaw == FLAW_END || flaw == FLAW_BOTH) begin
      e = 8'($urandom_range(255));
      if (e == END_MARK) e = 8'h00;
    end
    f[FRAME_BYTES-2] = s;
    f[FRAME_BYTES-1] = e;
    for (int p = 0; p < FRAME_BYTES; p++) byte_q.push_back(f[p]);
  endtask

  // noise leans on the flag bytes so that the hunt gets exercised
  task automatic add_noise(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 25) byte_q.push_back(FLAG_FIRST);
      else if (r < 35) byte_q.push_back(FLAG_SECOND);
      else byte_q.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic build_stimulus();
    int directed_len;
    int r;
    // hunt corner cases: lone second flag, first flag then other byte, repeated first flag
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    byte_q.push_back(FLAG_SECOND);
    byte_q.push_back(FLAG_FIRST);
    byte_q.push_back(8'h13);
    byte_q.push_back(FLAG_SECOND);
    byte_q.push_back(FLAG_FIRST);
    byte_q.push_back(FLAG_FIRST);
    add_frame(FLAW_NONE, PAT_SIGN);
    add_frame(FLAW_NONE, PAT_ZEROS);
    add_frame(FLAW_NONE, PAT_ONES);
    // rejected frame with headers inside: no rescan
    add_frame(FLAW_SUM, PAT_FLAGS);
    add_frame(FLAW_END, PAT_RANDOM);
    add_frame(FLAW_BOTH, PAT_RANDOM);
    add_frame(FLAW_NONE, PAT_FLAGS);
    directed_len = byte_q.size();

    while (byte_q.size() < directed_len + RANDOM_BYTES) begin
      r = $urandom_range(99);
      if (r < 65) add_frame(FLAW_NONE, PAT_RANDOM);
      else if (r < 75) add_frame(FLAW_SUM, PAT_RANDOM);
      else if (r < 83) add_frame(FLAW_END, PAT_RANDOM);
      else if (r < 93) add_noise($urandom_range(1, 6));
      else begin
        // truncated frame, swallowed by whatever follows
        byte_q.push_back(FLAG_FIRST);
        byte_q.push_back(FLAG_SECOND);
        add_noise($urandom_range(1, 30));
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    in_item_t item;
    if (rst) begin
      rx_if.valid <= 1'b0;
      rx_if.data  <= '0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= sender_idle_pct(idle_mode())) begin
        item.rx_byte = byte_q.pop_front();
        rx_if.data  <= item;
        rx_if.valid <= 1'b1;
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      tx_if.ready <= 1'b0;
    end else begin
      tx_if.ready <= ($urandom_range(99) >= receiver_stall_pct(idle_mode()));
    end
  end

  // monitor: predict on each byte transfer, check on each result transfer
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst) begin
      if (rx_if.valid && rx_if.ready) begin
        bytes_sent++;
        deframe_byte(rx_if.data.rx_byte);
      end
      if (tx_if.valid && tx_if.ready) begin
        got = tx_if.data;
        if (expected_fields.size() == 0) begin
          $error("unexpected result: kind %0d index %0d value %h last %0d",
                 got.result_kind, got.field_index, got.field_value, got.last);
          err_cnt++;
        end else begin
          want = expected_fields.pop_front();
          if (got.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
            err_cnt++;
          end
          if (got.field_index !== want.field_index) begin
            $error("field_index: expected %0d, got %0d", want.field_index, got.field_index);
            err_cnt++;
          end
          if (got.field_value !== want.field_value) begin
            $error("field_value: expected %h, got %h", want.field_value, got.field_value);
            err_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    build_stimulus();
    stim_total = byte_q.size();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (byte_q.size() != 0 || rx_if.valid) @(posedge clk);
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tfd_pkg.sv
sv/tfd_stream_if.sv
sv/telemetry_frame_deframer.sv
tb/telemetry_frame_deframer_tb.sv
